>>> design/md5_byte_stream_hasher_macros.svh
// Assertion macros for the MD5 byte-stream hasher.
`ifndef MD5_BYTE_STREAM_HASHER_MACROS_SVH
`define MD5_BYTE_STREAM_HASHER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MD5H_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define MD5H_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/md5h_pkg.sv
// Types, constants and round functions for the MD5 byte-stream hasher.
package md5h_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } md5h_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        final_word;
  } md5h_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } md5h_state_e;

  localparam logic [31:0] IvInit [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [3:0] LenLoWord = 4'd14;
  localparam logic [3:0] LenHiWord = 4'd15;
  localparam logic [3:0] LastWord  = 4'd15;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [1:0] LastLane  = 2'd3;
  localparam logic [2:0] LenGroup  = 3'd7;
  localparam logic [1:0] LastDigest = 2'd3;

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] k);
    logic [3:0] kk;
    logic [3:0] g;
    kk = k[3:0];
    unique case (k[5:4])
      2'd0:    g = kk;
      2'd1:    g = 4'(kk * 4'd5 + 4'd1);
      2'd2:    g = 4'(kk * 4'd3 + 4'd5);
      default: g = 4'(kk * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] phase,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
    logic [31:0] f;
    unique case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

>>> design/md5h_ram.sv
// Generic single-write, single-read RAM with registered read data.
module md5h_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/md5_byte_stream_hasher.sv
// MD5 digest of a byte stream; message block held in a 16-word RAM, one round per cycle.
// A byte transaction that leaves the block partial is stored, and the hasher stays ready for input.
// A full 64-byte block runs one transform: a load, 64 rounds from the word RAM, then an add.
// End of message: padding words are written up to word 15 ahead of each transform;
// one or two transforms, then four output transactions. Inputs stall meanwhile.
// Reset (async, active low) loads the initial vector and clears the bit count.
`include "md5_byte_stream_hasher_macros.svh"

module md5_byte_stream_hasher
  import md5h_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  md5h_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output md5h_out_t out_data_o
);

  md5h_state_e state_q, state_d;
  logic [63:0] cnt_q, cnt_d;
  logic [23:0] pack_q, pack_d;
  logic [3:0]  wi_q, wi_d;
  logic        first_q, first_d;
  logic        lenblk_q, lenblk_d;
  logic        fin_q, fin_d;
  logic        pad_q, pad_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [1:0]  oidx_q, oidx_d;
  logic [31:0] cv_q [4];
  logic [31:0] cv_d [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;

  logic        acc_in;
  logic [5:0]  pos_old;
  logic [5:0]  pos_new;
  logic        full;
  logic [31:0] pad_word;
  logic [31:0] t_sum;
  logic [31:0] rot;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  assign acc_in  = in_valid_i && in_ready_o;
  assign pos_old = cnt_q[8:3];
  assign full    = in_data_i.byte_present && (pos_old == LastByte);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o.digest_word = cv_q[oidx_q];
  assign out_data_o.word_number = oidx_q;
  assign out_data_o.final_word  = (oidx_q == LastDigest);

  always_comb begin
    pad_word = '0;
    if (first_q) begin
      for (int l = 0; l < 3; l++) begin
        if (2'(l) < pos_old[1:0]) begin
          pad_word[8*l +: 8] = pack_q[8*l +: 8];
        end
      end
      pad_word[8*pos_old[1:0] +: 8] = PadByte;
    end else if (lenblk_q && (wi_q == LenLoWord)) begin
      pad_word = cnt_q[31:0];
    end else if (lenblk_q && (wi_q == LenHiWord)) begin
      pad_word = cnt_q[63:32];
    end
  end

  assign t_sum = a_q + round_fn(rnd_q[5:4], b_q, c_q, d_q) + ram_rdata + RoundConst[rnd_q];
  assign rot   = rotl32(t_sum, RotAmount[{rnd_q[5:4], rnd_q[1:0]}]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          if (full) begin
            state_d = ST_LOAD;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (wi_q == LastWord) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (pad_q && lenblk_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ready_i && (oidx_q == LastDigest)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    pack_d   = pack_q;
    wi_d     = wi_q;
    first_d  = first_q;
    lenblk_d = lenblk_q;
    fin_d    = fin_q;
    pad_d    = pad_q;
    rnd_d    = rnd_q;
    oidx_d   = oidx_q;
    cv_d     = cv_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    d_d      = d_q;
    ram_we    = 1'b0;
    ram_waddr = wi_q;
    ram_wdata = pad_word;
    ram_raddr = msg_index(rnd_q + 6'd1);
    pos_new   = cnt_q[8:3];
    unique case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          if (in_data_i.byte_present) begin
            cnt_d = cnt_q + 64'd8;
            if (pos_old[1:0] == LastLane) begin
              ram_we    = 1'b1;
              ram_waddr = pos_old[5:2];
              ram_wdata = {in_data_i.data_byte, pack_q};
            end else begin
              for (int l = 0; l < 3; l++) begin
                if (2'(l) == pos_old[1:0]) begin
                  pack_d[8*l +: 8] = in_data_i.data_byte;
                end
              end
            end
          end
          fin_d   = in_data_i.end_of_message;
          pos_new = cnt_d[8:3];
          if (in_data_i.end_of_message && !full) begin
            wi_d     = pos_new[5:2];
            first_d  = 1'b1;
            lenblk_d = (pos_new[5:3] != LenGroup);
            pad_d    = 1'b1;
          end
        end
      end
      ST_PAD: begin
        ram_we  = 1'b1;
        wi_d    = wi_q + 4'd1;
        first_d = 1'b0;
      end
      ST_LOAD: begin
        ram_raddr = msg_index(6'd0);
        a_d   = cv_q[0];
        b_d   = cv_q[1];
        c_d   = cv_q[2];
        d_d   = cv_q[3];
        rnd_d = '0;
      end
      ST_ROUND: begin
        a_d   = d_q;
        d_d   = c_q;
        c_d   = b_q;
        b_d   = b_q + rot;
        rnd_d = rnd_q + 6'd1;
      end
      ST_ADD: begin
        cv_d[0] = cv_q[0] + a_q;
        cv_d[1] = cv_q[1] + b_q;
        cv_d[2] = cv_q[2] + c_q;
        cv_d[3] = cv_q[3] + d_q;
        if (fin_q) begin
          if (!pad_q) begin
            wi_d     = pos_new[5:2];
            first_d  = 1'b1;
            lenblk_d = (pos_new[5:3] != LenGroup);
            pad_d    = 1'b1;
          end else if (!lenblk_q) begin
            wi_d     = '0;
            first_d  = 1'b0;
            lenblk_d = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == LastDigest) begin
            cv_d  = IvInit;
            cnt_d = '0;
            fin_d = 1'b0;
            pad_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      wi_q     <= '0;
      first_q  <= 1'b0;
      lenblk_q <= 1'b0;
      fin_q    <= 1'b0;
      pad_q    <= 1'b0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      cv_q     <= IvInit;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      wi_q     <= wi_d;
      first_q  <= first_d;
      lenblk_q <= lenblk_d;
      fin_q    <= fin_d;
      pad_q    <= pad_d;
      rnd_q    <= rnd_d;
      oidx_q   <= oidx_d;
      cv_q     <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pack_q <= pack_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
  end

  md5h_ram #(
    .Width(32),
    .Depth(16)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  `MD5H_ASSERT(a_no_write_in_rounds, !(ram_we && (state_q == ST_LOAD || state_q == ST_ROUND)), "block RAM written during a transform")
  `MD5H_ASSERT(a_ready_valid_excl, !(in_ready_o && out_valid_o), "input taken while digest pending")
  `MD5H_ASSERT_NEXT(a_round_end, (state_q == ST_ROUND && rnd_q == LastRound), (state_q == ST_ADD), "transform did not end after the last round")
  `MD5H_ASSERT_NEXT(a_digest_done, (out_valid_o && out_ready_i && oidx_q == LastDigest), (state_q == ST_IDLE && cnt_q == '0 && cv_q[0] == IvInit[0]), "state not restored after digest")

endmodule
